// ----- rtl/pbadj_pkg.sv -----
// ----------------------------------------------------------------------------
// pbadj_pkg: shared definitions for the palette brightness adjuster
// Widths, register indexes, the hue sector code, the stage-to-stage payload
// and the small arithmetic helpers used by more than one pipeline stage.
// ----------------------------------------------------------------------------
package pbadj_pkg;

  // Palette size and field widths.
  localparam int unsigned PALETTE_ENTRIES = 256;
  localparam int unsigned ENTRY_W         = $clog2(PALETTE_ENTRIES);
  localparam int unsigned CH_W            = 6;
  localparam int unsigned SCALE_W         = 10;
  localparam int unsigned Q_FRAC          = 8;
  localparam int unsigned PROD_W          = 2 * CH_W;
  localparam int unsigned PACK_W          = 16;
  localparam int unsigned CFG_IDX_W       = 8;

  // Full-scale channel value and the unity brightness factor.
  localparam logic [CH_W-1:0]    CH_MAX      = 6'd63;
  localparam logic [SCALE_W-1:0] SCALE_UNITY = 10'd256;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS_SCALE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT_555 = 8'd1;

  // Hue sector of a color.
  typedef enum logic [2:0] {
    SECT_0 = 3'd0,
    SECT_1 = 3'd1,
    SECT_2 = 3'd2,
    SECT_3 = 3'd3,
    SECT_4 = 3'd4,
    SECT_5 = 3'd5
  } sector_e;

  // Payload handed from the color split half to the rebuild half.
  typedef struct packed {
    logic [ENTRY_W-1:0] entry_index;
    logic               last;
    logic [CH_W-1:0]    red;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    blue;
    sector_e            sector;
    logic [CH_W-1:0]    sat;
    logic [CH_W-1:0]    hue;
    logic [CH_W-1:0]    value;
  } split_t;

  // Truncating division by 63 for products of two channels. The estimate
  // x * 65 / 4096 is never high and at most one low, so one compare fixes it.
  function automatic logic [CH_W-1:0] div63(input logic [PROD_W-1:0] x);
    logic [PROD_W+6:0] est;
    logic [6:0]        q0;
    logic [PROD_W:0]   back;
    logic [PROD_W:0]   rem;
    logic [6:0]        q;
    est  = (PROD_W+7)'(x) + ((PROD_W+7)'(x) << 6);
    q0   = est[PROD_W+6:PROD_W];
    back = ((PROD_W+1)'(q0) << 6) - (PROD_W+1)'(q0);
    rem  = (PROD_W+1)'(x) - back;
    q    = (rem >= (PROD_W+1)'(CH_MAX)) ? q0 + 7'd1 : q0;
    return q[CH_W-1:0];
  endfunction

  // Packs three 6-bit channels into a 565 or a 555 word.
  function automatic logic [PACK_W-1:0] pack_color(
    input logic [CH_W-1:0] r,
    input logic [CH_W-1:0] g,
    input logic [CH_W-1:0] b,
    input logic            fmt_555
  );
    logic [PACK_W-1:0] word;
    if (fmt_555) begin
      word = {1'b0, r[CH_W-1:1], g[CH_W-1:1], b[CH_W-1:1]};
    end else begin
      word = {r[CH_W-1:1], g, b[CH_W-1:1]};
    end
    return word;
  endfunction

endpackage

// ----- rtl/palette_brightness_adjust_pack16_top.sv -----
// ----------------------------------------------------------------------------
// palette_brightness_adjust_pack16_top: palette entry brightness adjuster
// Usage:
//   An entry is taken at a rising edge with start_i high and busy_o low.
//   busy_o stays low, so a new entry may be started in every cycle.
//   Each result appears for exactly one cycle with done_o high; results
//   leave in start order, one per start, and the pipeline sustains one
//   entry per clock. The seven pipeline registers are input capture, two
//   stages of the saturation and hue dividers, then the product, the
//   first divide-by-63, the value product and the output register.
//   Configuration transactions on the cfg_* channel are always ready;
//   index 0 holds the Q8 brightness factor and index 1 selects 555 over
//   565 packing. Other indexes are ignored. Write them only while no entry
//   is in flight.
//   Reset clears the pipeline valid bits and sets the factor to unity and
//   the packing to 565. The receiver cannot stall, so no result is held.
// ----------------------------------------------------------------------------
module palette_brightness_adjust_pack16_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [pbadj_pkg::ENTRY_W-1:0]    entry_index_i,
  input  logic [pbadj_pkg::CH_W-1:0]       red_in_i,
  input  logic [pbadj_pkg::CH_W-1:0]       green_in_i,
  input  logic [pbadj_pkg::CH_W-1:0]       blue_in_i,
  input  logic                             last_in_i,
  output logic                             done_o,
  output logic [pbadj_pkg::ENTRY_W-1:0]    entry_index_out_o,
  output logic [pbadj_pkg::CH_W-1:0]       red_out_o,
  output logic [pbadj_pkg::CH_W-1:0]       green_out_o,
  output logic [pbadj_pkg::CH_W-1:0]       blue_out_o,
  output logic [pbadj_pkg::PACK_W-1:0]     packed_color_o,
  output logic                             last_out_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pbadj_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pbadj_pkg::SCALE_W-1:0]    cfg_data_i
);
  import pbadj_pkg::*;

  // Configuration registers.
  logic [SCALE_W-1:0] scale_q;
  logic               fmt_555_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q   <= SCALE_UNITY;
      fmt_555_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_BRIGHTNESS_SCALE: scale_q   <= cfg_data_i;
        REG_PIXEL_FORMAT_555: fmt_555_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The pipeline never stalls.
  assign busy_o = 1'b0;

  logic   split_valid;
  split_t split_data;

  pbadj_split u_split (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (start_i && !busy_o),
    .entry_index_i (entry_index_i),
    .red_i         (red_in_i),
    .green_i       (green_in_i),
    .blue_i        (blue_in_i),
    .last_i        (last_in_i),
    .scale_i       (scale_q),
    .valid_o       (split_valid),
    .data_o        (split_data)
  );

  pbadj_rebuild u_rebuild (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (split_valid),
    .data_i        (split_data),
    .bypass_i      (scale_q == SCALE_UNITY),
    .fmt_555_i     (fmt_555_q),
    .done_o        (done_o),
    .entry_index_o (entry_index_out_o),
    .red_o         (red_out_o),
    .green_o       (green_out_o),
    .blue_o        (blue_out_o),
    .packed_o      (packed_color_o),
    .last_o        (last_out_o)
  );

endmodule

// ----- rtl/pbadj_div.sv -----
// ----------------------------------------------------------------------------
// pbadj_div: two-stage pipelined restoring divider
// Divides a 12-bit numerator by a 6-bit divisor when the quotient is known to
// fit in six bits. Three quotient bits are resolved per stage.
// ----------------------------------------------------------------------------
module pbadj_div (
  input  logic                          clk_i,
  input  logic [pbadj_pkg::PROD_W-1:0]  num_i,
  input  logic [pbadj_pkg::CH_W-1:0]    den_i,
  output logic [pbadj_pkg::CH_W-1:0]    quo_o
);
  import pbadj_pkg::*;

  localparam int unsigned HALF   = CH_W / 2;
  localparam int unsigned REM1_W = CH_W + HALF;

  logic [PROD_W-1:0] rem_a;
  logic [HALF-1:0]   qhi_d;
  logic [REM1_W-1:0] rem_d, rem_q;
  logic [HALF-1:0]   qhi_q;
  logic [CH_W-1:0]   den_q;
  logic [REM1_W-1:0] rem_b;
  logic [HALF-1:0]   qlo_d;
  logic [CH_W-1:0]   quo_d, quo_q;

  // First stage: upper quotient bits.
  always_comb begin
    logic [PROD_W-1:0] dsh;
    rem_a = num_i;
    qhi_d = '0;
    for (int i = CH_W - 1; i >= int'(HALF); i--) begin
      dsh = PROD_W'(den_i) << i;
      if (rem_a >= dsh) begin
        rem_a = rem_a - dsh;
        qhi_d = {qhi_d[HALF-2:0], 1'b1};
      end else begin
        qhi_d = {qhi_d[HALF-2:0], 1'b0};
      end
    end
    rem_d = rem_a[REM1_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    qhi_q <= qhi_d;
    den_q <= den_i;
  end

  // Second stage: lower quotient bits.
  always_comb begin
    logic [REM1_W-1:0] dsh;
    rem_b = rem_q;
    qlo_d = '0;
    for (int i = HALF - 1; i >= 0; i--) begin
      dsh = REM1_W'(den_q) << i;
      if (rem_b >= dsh) begin
        rem_b = rem_b - dsh;
        qlo_d = {qlo_d[HALF-2:0], 1'b1};
      end else begin
        qlo_d = {qlo_d[HALF-2:0], 1'b0};
      end
    end
    quo_d = {qhi_q, qlo_d};
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
  end

  assign quo_o = quo_q;

endmodule

// ----- rtl/pbadj_split.sv -----
// ----------------------------------------------------------------------------
// pbadj_split: color split half of the pipeline
// Captures an entry, finds max, min and hue sector, divides out saturation
// and hue offset, and scales the value by the brightness factor.
// ----------------------------------------------------------------------------
module pbadj_split (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic [pbadj_pkg::ENTRY_W-1:0]    entry_index_i,
  input  logic [pbadj_pkg::CH_W-1:0]       red_i,
  input  logic [pbadj_pkg::CH_W-1:0]       green_i,
  input  logic [pbadj_pkg::CH_W-1:0]       blue_i,
  input  logic                             last_i,
  input  logic [pbadj_pkg::SCALE_W-1:0]    scale_i,
  output logic                             valid_o,
  output pbadj_pkg::split_t                data_o
);
  import pbadj_pkg::*;

  localparam int unsigned VP_W = SCALE_W + CH_W;

  // Side-band payload that travels beside the dividers.
  typedef struct packed {
    logic [ENTRY_W-1:0] entry_index;
    logic               last;
    logic [CH_W-1:0]    red;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    blue;
    sector_e            sector;
    logic               hue_inv;
    logic               mx_zero;
  } side_t;

  // Stage A: input capture.
  logic               a_valid_q;
  logic [ENTRY_W-1:0] a_idx_q;
  logic               a_last_q;
  logic [CH_W-1:0]    a_red_q, a_green_q, a_blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_idx_q   <= entry_index_i;
    a_last_q  <= last_i;
    a_red_q   <= red_i;
    a_green_q <= green_i;
    a_blue_q  <= blue_i;
  end

  // Max, min, spread and hue sector of the captured color.
  logic [CH_W-1:0]   mx, mn, spread, hdiff;
  sector_e           sector;
  logic              hue_inv;
  logic [PROD_W-1:0] num_sat, num_hue;

  always_comb begin
    if (a_red_q >= a_green_q && a_red_q >= a_blue_q) begin
      mx = a_red_q;
    end else if (a_green_q >= a_blue_q) begin
      mx = a_green_q;
    end else begin
      mx = a_blue_q;
    end
    if (a_red_q <= a_green_q && a_red_q <= a_blue_q) begin
      mn = a_red_q;
    end else if (a_green_q <= a_blue_q) begin
      mn = a_green_q;
    end else begin
      mn = a_blue_q;
    end
    spread = mx - mn;
  end

  always_comb begin
    if (a_red_q == mx) begin
      if (a_green_q >= a_blue_q) begin
        sector = SECT_0; hdiff = a_green_q - a_blue_q; hue_inv = 1'b0;
      end else begin
        sector = SECT_5; hdiff = a_blue_q - a_green_q; hue_inv = 1'b1;
      end
    end else if (a_green_q == mx) begin
      if (a_blue_q >= a_red_q) begin
        sector = SECT_2; hdiff = a_blue_q - a_red_q; hue_inv = 1'b0;
      end else begin
        sector = SECT_1; hdiff = a_red_q - a_blue_q; hue_inv = 1'b1;
      end
    end else if (a_red_q >= a_green_q) begin
      sector = SECT_4; hdiff = a_red_q - a_green_q; hue_inv = 1'b0;
    end else begin
      sector = SECT_3; hdiff = a_green_q - a_red_q; hue_inv = 1'b1;
    end
  end

  // Numerators scaled by 63.
  assign num_sat = (PROD_W'(spread) << CH_W) - PROD_W'(spread);
  assign num_hue = (PROD_W'(hdiff) << CH_W) - PROD_W'(hdiff);

  // Saturation and hue offset dividers, two stages each.
  logic [CH_W-1:0] sat_quo, hue_quo;

  pbadj_div u_div_sat (
    .clk_i (clk_i),
    .num_i (num_sat),
    .den_i (mx),
    .quo_o (sat_quo)
  );

  pbadj_div u_div_hue (
    .clk_i (clk_i),
    .num_i (num_hue),
    .den_i (spread),
    .quo_o (hue_quo)
  );

  // Stage B: side-band beside the first divider stage.
  logic            b_valid_q;
  side_t           b_side_q;
  logic [CH_W-1:0] b_mx_q;
  side_t           b_side_d;

  always_comb begin
    b_side_d.entry_index = a_idx_q;
    b_side_d.last        = a_last_q;
    b_side_d.red         = a_red_q;
    b_side_d.green       = a_green_q;
    b_side_d.blue        = a_blue_q;
    b_side_d.sector      = sector;
    b_side_d.hue_inv     = hue_inv;
    b_side_d.mx_zero     = (mx == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_side_q <= b_side_d;
    b_mx_q   <= mx;
  end

  // Value scaled by the Q8 brightness factor, saturated at full scale.
  logic [VP_W-1:0]       vprod;
  logic [VP_W-Q_FRAC-1:0] vshift;
  logic [CH_W-1:0]       value_d;

  assign vprod   = VP_W'(scale_i) * VP_W'(b_mx_q);
  assign vshift  = vprod[VP_W-1:Q_FRAC];
  assign value_d = (|vshift[VP_W-Q_FRAC-1:CH_W]) ? CH_MAX : vshift[CH_W-1:0];

  // Stage C: side-band beside the second divider stage.
  logic            c_valid_q;
  side_t           c_side_q;
  logic [CH_W-1:0] c_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_side_q  <= b_side_q;
    c_value_q <= value_d;
  end

  // A black color has zero saturation; the inverted sectors count down.
  always_comb begin
    data_o.entry_index = c_side_q.entry_index;
    data_o.last        = c_side_q.last;
    data_o.red         = c_side_q.red;
    data_o.green       = c_side_q.green;
    data_o.blue        = c_side_q.blue;
    data_o.sector      = c_side_q.sector;
    data_o.sat         = c_side_q.mx_zero ? '0 : sat_quo;
    data_o.hue         = c_side_q.hue_inv ? CH_MAX - hue_quo : hue_quo;
    data_o.value       = c_value_q;
  end

  assign valid_o = c_valid_q;

endmodule

// ----- rtl/pbadj_rebuild.sv -----
// ----------------------------------------------------------------------------
// pbadj_rebuild: color rebuild half of the pipeline
// Forms the low, rising and falling channel levels for the sector, selects
// the channels, applies bypass and packs the 16-bit word.
// ----------------------------------------------------------------------------
module pbadj_rebuild (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  pbadj_pkg::split_t                data_i,
  input  logic                             bypass_i,
  input  logic                             fmt_555_i,
  output logic                             done_o,
  output logic [pbadj_pkg::ENTRY_W-1:0]    entry_index_o,
  output logic [pbadj_pkg::CH_W-1:0]       red_o,
  output logic [pbadj_pkg::CH_W-1:0]       green_o,
  output logic [pbadj_pkg::CH_W-1:0]       blue_o,
  output logic [pbadj_pkg::PACK_W-1:0]     packed_o,
  output logic                             last_o
);
  import pbadj_pkg::*;

  // Payload that rides along unchanged through the rebuild stages.
  typedef struct packed {
    logic [ENTRY_W-1:0] entry_index;
    logic               last;
    logic [CH_W-1:0]    red;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    blue;
    sector_e            sector;
    logic [CH_W-1:0]    value;
    logic               sat_zero;
  } meta_t;

  meta_t meta_d;

  always_comb begin
    meta_d.entry_index = data_i.entry_index;
    meta_d.last        = data_i.last;
    meta_d.red         = data_i.red;
    meta_d.green       = data_i.green;
    meta_d.blue        = data_i.blue;
    meta_d.sector      = data_i.sector;
    meta_d.value       = data_i.value;
    meta_d.sat_zero    = (data_i.sat == '0);
  end

  // Stage D: saturation products.
  logic              d_valid_q;
  meta_t             d_meta_q;
  logic [PROD_W-1:0] d_p_off_q, d_p_inv_q, d_p_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else begin
      d_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    d_meta_q  <= meta_d;
    d_p_off_q <= PROD_W'(data_i.sat) * PROD_W'(data_i.hue);
    d_p_inv_q <= PROD_W'(data_i.sat) * PROD_W'(CH_MAX - data_i.hue);
    d_p_low_q <= PROD_W'(data_i.value) * PROD_W'(CH_MAX - data_i.sat);
  end

  // Stage E: first division by 63 and the complements.
  logic            e_valid_q;
  meta_t           e_meta_q;
  logic [CH_W-1:0] e_t_off_q, e_t_inv_q, e_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else begin
      e_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e_meta_q  <= d_meta_q;
    e_t_off_q <= CH_MAX - div63(d_p_off_q);
    e_t_inv_q <= CH_MAX - div63(d_p_inv_q);
    e_low_q   <= div63(d_p_low_q);
  end

  // Stage F: value times the complements.
  logic              f_valid_q;
  meta_t             f_meta_q;
  logic [PROD_W-1:0] f_m_off_q, f_m_inv_q;
  logic [CH_W-1:0]   f_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= e_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f_meta_q  <= e_meta_q;
    f_m_off_q <= PROD_W'(e_meta_q.value) * PROD_W'(e_t_off_q);
    f_m_inv_q <= PROD_W'(e_meta_q.value) * PROD_W'(e_t_inv_q);
    f_low_q   <= e_low_q;
  end

  // Final division, sector select, grey and bypass.
  logic [CH_W-1:0] off, inv, v;
  logic [CH_W-1:0] red_d, green_d, blue_d;

  assign off = div63(f_m_off_q);
  assign inv = div63(f_m_inv_q);
  assign v   = f_meta_q.value;

  always_comb begin
    if (bypass_i) begin
      red_d   = f_meta_q.red;
      green_d = f_meta_q.green;
      blue_d  = f_meta_q.blue;
    end else if (f_meta_q.sat_zero) begin
      red_d   = v;
      green_d = v;
      blue_d  = v;
    end else begin
      case (f_meta_q.sector)
        SECT_0: begin
          red_d = v;       green_d = inv;     blue_d = f_low_q;
        end
        SECT_1: begin
          red_d = off;     green_d = v;       blue_d = f_low_q;
        end
        SECT_2: begin
          red_d = f_low_q; green_d = v;       blue_d = inv;
        end
        SECT_3: begin
          red_d = f_low_q; green_d = off;     blue_d = v;
        end
        SECT_4: begin
          red_d = inv;     green_d = f_low_q; blue_d = v;
        end
        default: begin
          red_d = v;       green_d = f_low_q; blue_d = off;
        end
      endcase
    end
  end

  // Stage G: output registers.
  logic               done_q;
  logic [ENTRY_W-1:0] idx_q;
  logic [CH_W-1:0]    red_q, green_q, blue_q;
  logic [PACK_W-1:0]  packed_q;
  logic               last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= f_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= f_meta_q.entry_index;
    last_q   <= f_meta_q.last;
    red_q    <= red_d;
    green_q  <= green_d;
    blue_q   <= blue_d;
    packed_q <= pack_color(red_d, green_d, blue_d, fmt_555_i);
  end

  assign done_o        = done_q;
  assign entry_index_o = idx_q;
  assign red_o         = red_q;
  assign green_o       = green_q;
  assign blue_o        = blue_q;
  assign packed_o      = packed_q;
  assign last_o        = last_q;

endmodule

// ----- dv/palette_brightness_adjust_pack16_top_tb.sv -----
// ----------------------------------------------------------------------------
// palette_brightness_adjust_pack16_top_tb: brightness adjuster testbench
// Streams palette entries into the adjuster under several brightness and
// packing settings. A behavioral predictor computes each adjusted entry at
// the start handshake, and a monitor checks every done strobe against the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module palette_brightness_adjust_pack16_top_tb;

  import pbadj_pkg::*;

  // One predicted adjusted entry.
  typedef struct {
    logic [ENTRY_W-1:0] entry_index;
    logic [CH_W-1:0]    red;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    blue;
    logic [PACK_W-1:0]  packed_color;
    logic               last;
  } adjusted_entry_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic [ENTRY_W-1:0]   entry_index_i;
  logic [CH_W-1:0]      red_in_i;
  logic [CH_W-1:0]      green_in_i;
  logic [CH_W-1:0]      blue_in_i;
  logic                 last_in_i;
  logic                 done_o;
  logic [ENTRY_W-1:0]   entry_index_out_o;
  logic [CH_W-1:0]      red_out_o;
  logic [CH_W-1:0]      green_out_o;
  logic [CH_W-1:0]      blue_out_o;
  logic [PACK_W-1:0]    packed_color_o;
  logic                 last_out_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [SCALE_W-1:0]   cfg_data_i;

  // Shadow copy of the configuration registers.
  int unsigned          scale_q8;
  logic                 fmt_555;

  adjusted_entry_t      pending_entries[$];
  int unsigned          mismatch_count;
  bit                   idling_on;

  palette_brightness_adjust_pack16_top u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .entry_index_i     (entry_index_i),
    .red_in_i          (red_in_i),
    .green_in_i        (green_in_i),
    .blue_in_i         (blue_in_i),
    .last_in_i         (last_in_i),
    .done_o            (done_o),
    .entry_index_out_o (entry_index_out_o),
    .red_out_o         (red_out_o),
    .green_out_o       (green_out_o),
    .blue_out_o        (blue_out_o),
    .packed_color_o    (packed_color_o),
    .last_out_o        (last_out_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // Clock with a period of 10.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Computes the adjusted entry for the current register settings.
  function automatic adjusted_entry_t predict_entry(
    input logic [ENTRY_W-1:0] idx,
    input logic [CH_W-1:0]    r_in,
    input logic [CH_W-1:0]    g_in,
    input logic [CH_W-1:0]    b_in,
    input logic               last
  );
    adjusted_entry_t res;
    int unsigned r, g, b, mx, mn, d, sat, hue, v, low, off, inv;
    sector_e sect;
    r    = r_in;
    g    = g_in;
    b    = b_in;
    sat  = 0;
    hue  = 0;
    sect = SECT_0;
    if (scale_q8 != 256) begin
      // Max and min with ties going to red, then green.
      if (r >= g && r >= b) mx = r;
      else mx = (g >= r && g >= b) ? g : b;
      if (r <= g && r <= b) mn = r;
      else mn = (g <= r && g <= b) ? g : b;
      d = mx - mn;
      if (mx != 0) sat = (63 * d) / mx;
      // Hue sector and offset within it.
      if (sat != 0 && d != 0) begin
        if (r == mx) begin
          if (g >= b) begin
            sect = SECT_0;
            hue  = (63 * (g - b)) / d;
          end else begin
            sect = SECT_5;
            hue  = 63 - (63 * (b - g)) / d;
          end
        end else if (g == mx) begin
          if (b >= r) begin
            sect = SECT_2;
            hue  = (63 * (b - r)) / d;
          end else begin
            sect = SECT_1;
            hue  = 63 - (63 * (r - b)) / d;
          end
        end else if (r >= g) begin
          sect = SECT_4;
          hue  = (63 * (r - g)) / d;
        end else begin
          sect = SECT_3;
          hue  = 63 - (63 * (g - r)) / d;
        end
      end
      // Scaled value, saturated at full scale.
      v = (scale_q8 * mx) >> 8;
      if (v > 63) v = 63;
      // Rebuild the color; zero saturation gives grey.
      if (sat != 0) begin
        low = (v * (63 - sat)) / 63;
        off = (v * (63 - (sat * hue) / 63)) / 63;
        inv = (v * (63 - (sat * (63 - hue)) / 63)) / 63;
        case (sect)
          SECT_0: begin r = v;   g = inv; b = low; end
          SECT_1: begin r = off; g = v;   b = low; end
          SECT_2: begin r = low; g = v;   b = inv; end
          SECT_3: begin r = low; g = off; b = v;   end
          SECT_4: begin r = inv; g = low; b = v;   end
          default: begin r = v;  g = low; b = off; end
        endcase
      end else begin
        r = v;
        g = v;
        b = v;
      end
    end
    res.entry_index = idx;
    res.red         = r[CH_W-1:0];
    res.green       = g[CH_W-1:0];
    res.blue        = b[CH_W-1:0];
    res.last        = last;
    if (fmt_555) begin
      res.packed_color = {1'b0, res.red[5:1], res.green[5:1], res.blue[5:1]};
    end else begin
      res.packed_color = {res.red[5:1], res.green, res.blue[5:1]};
    end
    return res;
  endfunction

  // Sends one entry and records its prediction once the transaction is taken.
  // start_i is left high so that a following entry can go out back to back.
  task automatic send_entry(
    input logic [ENTRY_W-1:0] idx,
    input logic [CH_W-1:0]    r,
    input logic [CH_W-1:0]    g,
    input logic [CH_W-1:0]    b,
    input logic               last
  );
    @(negedge clk_i);
    start_i       = 1'b1;
    entry_index_i = idx;
    red_in_i      = r;
    green_in_i    = g;
    blue_in_i     = b;
    last_in_i     = last;
    do @(posedge clk_i); while (busy_o);
    pending_entries.push_back(predict_entry(idx, r, g, b, last));
  endtask

  // Drops start for a burst of idle cycles.
  task automatic idle_gap(input int unsigned cycles);
    @(negedge clk_i);
    start_i = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Writes one register once every entry in flight has come out.
  task automatic write_register(
    input logic [CFG_IDX_W-1:0] index,
    input logic [SCALE_W-1:0]   data
  );
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending_entries.size() != 0) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = index;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (index == REG_BRIGHTNESS_SCALE) scale_q8 = data;
    else if (index == REG_PIXEL_FORMAT_555) fmt_555 = data[0];
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Sends one random entry, biased toward grey and full-scale channels.
  task automatic send_random_entry();
    logic [CH_W-1:0] r, g, b;
    r = CH_W'($urandom_range(0, 63));
    g = CH_W'($urandom_range(0, 63));
    b = CH_W'($urandom_range(0, 63));
    case ($urandom_range(0, 7))
      0: begin g = r; b = r; end
      1: r = CH_MAX;
      2: g = b;
      3: begin r = CH_W'($urandom_range(0, 1) * 63); b = 6'd0; end
      default: ;
    endcase
    send_entry(ENTRY_W'($urandom), r, g, b, 1'($urandom));
    if (idling_on && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 16));
  endtask

  // Fixed colors: black, white, every sector, channel ties and greys.
  task automatic send_directed_colors(input int unsigned count);
    logic [CH_W-1:0] colors[13][3];
    colors = '{'{0, 0, 0}, '{63, 63, 63}, '{63, 0, 0}, '{63, 20, 40},
               '{30, 63, 10}, '{10, 63, 30}, '{10, 20, 63}, '{20, 10, 63},
               '{40, 40, 20}, '{20, 40, 40}, '{40, 20, 40}, '{32, 32, 32},
               '{1, 0, 0}};
    for (int i = 0; i < count; i++) begin
      send_entry((i % 2) ? 8'd255 : 8'd0, colors[i][0], colors[i][1],
                 colors[i][2], 1'(i % 2));
    end
  endtask

  // Unity brightness after reset: channels must pass through, 565 packing.
  task automatic test_bypass_after_reset();
    send_directed_colors(13);
  endtask

  // A non-unity factor with 555 packing over the first twelve colors of the set.
  task automatic test_scaled_555();
    write_register(REG_BRIGHTNESS_SCALE, 10'd200);
    write_register(REG_PIXEL_FORMAT_555, 10'd1);
    send_directed_colors(12);
  endtask

  // Writes to indexes with no register behind them must change nothing.
  task automatic test_unused_index();
    write_register(8'd2, 10'd1023);
    write_register(8'd255, 10'd0);
    for (int i = 0; i < 20; i++) send_random_entry();
  endtask

  // Random streams under a series of settings, extremes included.
  task automatic test_random_settings();
    int unsigned scales[8];
    scales = '{0, 1023, 256, 255, 257, 1, 0, 0};
    scales[6] = $urandom_range(0, 1023);
    scales[7] = $urandom_range(0, 1023);
    for (int p = 0; p < 8; p++) begin
      write_register(REG_BRIGHTNESS_SCALE, SCALE_W'(scales[p]));
      write_register(REG_PIXEL_FORMAT_555, SCALE_W'(p % 2));
      idling_on = (p != 7);
      for (int i = 0; i < 170; i++) send_random_entry();
    end
  endtask

  // Checks each done strobe against the oldest prediction.
  always @(posedge clk_i) begin
    adjusted_entry_t exp_entry;
    if (rst_ni && done_o) begin
      if (pending_entries.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("tb: result with nothing pending");
      end else begin
        exp_entry = pending_entries.pop_front();
        if (entry_index_out_o !== exp_entry.entry_index ||
            red_out_o !== exp_entry.red || green_out_o !== exp_entry.green ||
            blue_out_o !== exp_entry.blue ||
            packed_color_o !== exp_entry.packed_color ||
            last_out_o !== exp_entry.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("tb: mismatch exp idx=%0d rgb=%0d,%0d,%0d pack=%h last=%b",
                     exp_entry.entry_index, exp_entry.red, exp_entry.green,
                     exp_entry.blue, exp_entry.packed_color, exp_entry.last);
            $display("tb:          got idx=%0d rgb=%0d,%0d,%0d pack=%h last=%b",
                     entry_index_out_o, red_out_o, green_out_o, blue_out_o,
                     packed_color_o, last_out_o);
          end
        end
      end
    end
  end

  // Main sequence.
  initial begin
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    entry_index_i  = '0;
    red_in_i       = '0;
    green_in_i     = '0;
    blue_in_i      = '0;
    last_in_i      = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    scale_q8       = 256;
    fmt_555        = 1'b0;
    mismatch_count = 0;
    idling_on      = 1'b1;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    test_bypass_after_reset();
    test_scaled_555();
    test_unused_index();
    test_random_settings();

    // Drain the pipeline, then keep watching for stray strobes.
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending_entries.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/pbadj_pkg.sv
rtl/pbadj_div.sv
rtl/pbadj_split.sv
rtl/pbadj_rebuild.sv
rtl/palette_brightness_adjust_pack16_top.sv
dv/palette_brightness_adjust_pack16_top_tb.sv
